// ===== sv/pcpa_pkg.sv =====
// Shared types and codes of the per-CPU page allocator.
package pcpa_pkg;

   typedef logic [1:0]  op_type;
   typedef logic [1:0]  status_type;
   typedef logic [0:0]  csr_index_type;
   typedef logic [31:0] word_type;

   // request operation codes
   localparam op_type OP_INIT  = 2'd0;
   localparam op_type OP_ALLOC = 2'd1;
   localparam op_type OP_FREE  = 2'd2;

   // response status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_BAD   = 2'd2;

   // configuration register indexes
   localparam csr_index_type CSR_KERNEL_END = 1'b0;
   localparam csr_index_type CSR_PHYS_TOP   = 1'b1;

   localparam word_type KERNEL_END_RESET = 32'h8002_0000;
   localparam word_type PHYS_TOP_RESET   = 32'h8800_0000;

endpackage

// ===== sv/pcpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pcpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                                  clock,
   input  logic                                  write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                      write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                      read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// ===== sv/pcpa_div.sv =====
// Divide by a constant through a reciprocal multiply, quotient and done registered in the cycle after start.
module pcpa_div #(
   parameter int WIDTH   = 20,
   parameter int DIVISOR = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   // floor(x / DIVISOR) == (x * RECIP) >> (WIDTH + SHIFT) for every WIDTH-bit x
   localparam int              SHIFT   = $clog2(DIVISOR);
   localparam int              RECIP_W = WIDTH + 1;
   localparam int              PROD_W  = 2 * WIDTH + 1 + SHIFT;
   localparam longint unsigned SCALE   = 64'd1 << (WIDTH + SHIFT);
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   logic [PROD_W-1:0] product;
   logic [WIDTH-1:0]  quo_ff, quo_in;
   logic              done_ff, done_in;

   always_comb begin
      product = PROD_W'(dividend) * PROD_W'(RECIP);
      quo_in  = start ? product[WIDTH+SHIFT +: WIDTH] : quo_ff;
      done_in = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/per_cpu_page_free_list_allocator.sv =====
// Top level of the per-CPU free-list page allocator with stealing.
//
// One LIFO free list of pages per CPU. List heads sit in a small head RAM
// (index) plus one valid flop per CPU; the lists are chained through a link
// RAM indexed by page number from the region base. Both RAMs have one write
// and one registered read port. A request is taken when start is high and busy
// is low; exactly one response follows, shown for one cycle with rsp_valid
// high. The receiver cannot stall it, so it must take every strobe.
// Steps from accept: alloc selects a list and reads its head, reads the link,
// then writes the head back; alloc with all lists empty answers after the
// selection. Free checks the address while reading the head, then writes link
// and head; a bad free answers after the check; an unused opcode answers
// straight from idle. Init splits the page count by CPU_COUNT with a
// reciprocal multiply, then for every CPU sets up, pushes pages through the
// single link RAM write port until the final bound check fails, and writes
// the head. Alloc takes its own list first, else steals the lowest-numbered
// non-empty list from the valid flops in the same cycle. PAGE_BYTES must be a
// power of two. Configuration writes are taken at any time (csr_ready is tied
// high) but belong to idle periods; the region base is captured from kernel_end at each init.
module per_cpu_page_free_list_allocator
   import pcpa_pkg::*;
#(
   parameter int CPU_COUNT  = 8,
   parameter int PAGE_BYTES = 4096,
   parameter int MAX_PAGES  = 32768
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          start,
   output logic          busy,
   input  op_type        req_operation,
   input  logic [2:0]    req_cpu,
   input  word_type      req_address,
   // response channel
   output logic          rsp_valid,
   output word_type      rsp_page_address,
   output status_type    rsp_status,
   output logic [2:0]    rsp_source_cpu,
   // configuration channel
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  word_type      csr_data
);

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int CPU_W      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int TW         = 32 - PAGE_SHIFT;          // page count of a 32-bit span
   localparam int PW         = TW + 1;                   // page number incl. round-up carry
   localparam int CW         = (PW + 1 > IDX_W + 2) ? PW + 1 : IDX_W + 2;

   localparam logic [PW-1:0] BASE_PAGE_RESET =
      PW'((64'(KERNEL_END_RESET) + 64'(PAGE_BYTES) - 64'd1) >> PAGE_SHIFT);

   // sequencer states
   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_INIT_START = 4'd1;
   localparam logic [3:0] ST_INIT_DIV   = 4'd2;
   localparam logic [3:0] ST_INIT_CPU   = 4'd3;
   localparam logic [3:0] ST_INIT_PUSH  = 4'd4;
   localparam logic [3:0] ST_INIT_HEAD  = 4'd5;
   localparam logic [3:0] ST_ALLOC_SEL  = 4'd6;
   localparam logic [3:0] ST_ALLOC_HEAD = 4'd7;
   localparam logic [3:0] ST_ALLOC_LINK = 4'd8;
   localparam logic [3:0] ST_FREE_CHK   = 4'd9;
   localparam logic [3:0] ST_FREE_WRITE = 4'd10;

   // requester index wraps modulo CPU_COUNT; narrow value, small fixed loop
   function automatic logic [CPU_W-1:0] cpu_wrap(input logic [2:0] v);
      logic [2:0] r;
      r = v;
      for (int k = 0; k < 8; k++) begin
         if (int'(r) >= CPU_COUNT) begin
            r = r - 3'(CPU_COUNT);
         end
      end
      return CPU_W'(r);
   endfunction

   // ---------------------------------------------------------------- registers
   logic [3:0]           state_ff, state_in;
   logic [CPU_COUNT-1:0] head_valid_ff, head_valid_in;
   word_type             csr_kernel_end_ff, csr_kernel_end_in;
   word_type             csr_phys_top_ff, csr_phys_top_in;
   logic [PW-1:0]        base_page_ff, base_page_in;

   logic [CPU_W-1:0]     req_cpu_ff, req_cpu_in;
   word_type             req_address_ff, req_address_in;
   logic [CPU_W-1:0]     src_ff, src_in;
   logic [CW-1:0]        idx_ff, idx_in;

   logic [TW-1:0]        per_ff, per_in;
   logic [TW-1:0]        first_ff, first_in;
   logic [TW-1:0]        next_first_ff, next_first_in;
   logic [CPU_W-1:0]     init_cpu_ff, init_cpu_in;
   logic                 prev_valid_ff, prev_valid_in;
   logic [IDX_W-1:0]     prev_idx_ff, prev_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             rsp_page_address_ff, rsp_page_address_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [2:0]           rsp_source_cpu_ff, rsp_source_cpu_in;

   // ---------------------------------------------------------------- RAM ports
   logic                 head_we;
   logic [CPU_W-1:0]     head_waddr, head_raddr;
   logic [IDX_W-1:0]     head_wdata, head_rdata;
   logic                 link_we;
   logic [IDX_W-1:0]     link_waddr, link_raddr;
   logic [IDX_W:0]       link_wdata, link_rdata;

   logic                 div_start, div_done;
   logic [TW-1:0]        div_quotient;

   // ---------------------------------------------------------------- region math
   logic [PW-1:0]        kend_page;
   logic                 kend_unaligned;
   logic [PW-1:0]        init_base;
   logic [PW-1:0]        top_page;
   word_type             span_bytes;
   logic [TW-1:0]        span_page_count;

   always_comb begin
      kend_page       = PW'(csr_kernel_end_ff[31:PAGE_SHIFT]);
      kend_unaligned  = |csr_kernel_end_ff[PAGE_SHIFT-1:0];
      init_base       = kend_page + PW'(kend_unaligned);
      top_page        = PW'(csr_phys_top_ff[31:PAGE_SHIFT]);
      span_bytes      = csr_phys_top_ff - csr_kernel_end_ff;
      span_page_count = (csr_phys_top_ff > csr_kernel_end_ff) ?
                        span_bytes[31:PAGE_SHIFT] : '0;
   end

   // Init walk: non-last CPUs stop where the next share begins (one page less
   // when kernel_end is unaligned); the last CPU runs up to phys_top.
   logic init_last;
   logic push_ok;

   always_comb begin
      init_last = (init_cpu_ff == CPU_W'(CPU_COUNT - 1));
      if (init_last) begin
         push_ok = (idx_ff + CW'(init_base)) < CW'(top_page);
      end else begin
         push_ok = (idx_ff + CW'(kend_unaligned)) < CW'(next_first_ff);
      end
      push_ok = push_ok && (idx_ff < CW'(MAX_PAGES));
   end

   // Free address check against config and captured base.
   logic [CW-1:0] free_page;
   logic [CW-1:0] free_off;
   logic          free_bad;

   always_comb begin
      free_page = CW'(req_address_ff[31:PAGE_SHIFT]);
      free_off  = free_page - CW'(base_page_ff);
      free_bad  = (|req_address_ff[PAGE_SHIFT-1:0]) ||
                  (req_address_ff < csr_kernel_end_ff) ||
                  (req_address_ff >= csr_phys_top_ff) ||
                  (free_page < CW'(base_page_ff)) ||
                  (free_off >= CW'(MAX_PAGES));
   end

   // Own list first, else the lowest-numbered non-empty list.
   logic             sel_found;
   logic [CPU_W-1:0] sel_cpu;

   always_comb begin
      sel_found = 1'b0;
      sel_cpu   = '0;
      for (int i = CPU_COUNT - 1; i >= 0; i--) begin
         if (head_valid_ff[i]) begin
            sel_found = 1'b1;
            sel_cpu   = CPU_W'(i);
         end
      end
      if (head_valid_ff[req_cpu_ff]) begin
         sel_cpu = req_cpu_ff;
      end
   end

   logic [CW-1:0]          page_sum;
   logic [CW+PAGE_SHIFT-1:0] page_bytes;

   always_comb begin
      page_sum   = CW'(base_page_ff) + idx_ff;
      page_bytes = {page_sum, {PAGE_SHIFT{1'b0}}};
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in            = state_ff;
      head_valid_in       = head_valid_ff;
      base_page_in        = base_page_ff;
      req_cpu_in          = req_cpu_ff;
      req_address_in      = req_address_ff;
      src_in              = src_ff;
      idx_in              = idx_ff;
      per_in              = per_ff;
      first_in            = first_ff;
      next_first_in       = next_first_ff;
      init_cpu_in         = init_cpu_ff;
      prev_valid_in       = prev_valid_ff;
      prev_idx_in         = prev_idx_ff;

      rsp_valid_in        = 1'b0;
      rsp_page_address_in = '0;
      rsp_status_in       = STATUS_OK;
      rsp_source_cpu_in   = '0;

      head_we    = 1'b0;
      head_waddr = req_cpu_ff;
      head_wdata = prev_idx_ff;
      head_raddr = req_cpu_ff;
      link_we    = 1'b0;
      link_waddr = idx_ff[IDX_W-1:0];
      link_wdata = {prev_valid_ff, prev_idx_ff};
      link_raddr = head_rdata;
      div_start  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_cpu_in     = cpu_wrap(req_cpu);
               req_address_in = req_address;
               unique case (req_operation)
                  OP_INIT:  state_in = ST_INIT_START;
                  OP_ALLOC: state_in = ST_ALLOC_SEL;
                  OP_FREE:  state_in = ST_FREE_CHK;
                  default:  rsp_valid_in = 1'b1;      // unused code: zero result
               endcase
            end
         end

         ST_INIT_START: begin
            div_start     = 1'b1;
            head_valid_in = '0;
            base_page_in  = init_base;
            state_in      = ST_INIT_DIV;
         end

         ST_INIT_DIV: begin
            if (div_done) begin
               per_in      = div_quotient;
               init_cpu_in = '0;
               first_in    = '0;
               state_in    = ST_INIT_CPU;
            end
         end

         ST_INIT_CPU: begin
            idx_in        = CW'(first_ff);
            next_first_in = first_ff + per_ff;
            prev_valid_in = 1'b0;
            state_in      = ST_INIT_PUSH;
         end

         ST_INIT_PUSH: begin
            if (push_ok) begin
               link_we       = 1'b1;
               prev_valid_in = 1'b1;
               prev_idx_in   = idx_ff[IDX_W-1:0];
               idx_in        = idx_ff + CW'(1);
            end else begin
               state_in = ST_INIT_HEAD;
            end
         end

         ST_INIT_HEAD: begin
            head_we                    = 1'b1;
            head_waddr                 = init_cpu_ff;
            head_valid_in[init_cpu_ff] = prev_valid_ff;
            if (init_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               init_cpu_in = CPU_W'(init_cpu_ff + 1'b1);
               first_in    = next_first_ff;
               state_in    = ST_INIT_CPU;
            end
         end

         ST_ALLOC_SEL: begin
            head_raddr = sel_cpu;
            if (sel_found) begin
               src_in   = sel_cpu;
               state_in = ST_ALLOC_HEAD;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_EMPTY;
               state_in      = ST_IDLE;
            end
         end

         ST_ALLOC_HEAD: begin
            link_raddr = head_rdata;
            idx_in     = CW'(head_rdata);
            state_in   = ST_ALLOC_LINK;
         end

         ST_ALLOC_LINK: begin
            // pop: the link of the old head becomes the new head
            head_we               = 1'b1;
            head_waddr            = src_ff;
            head_wdata            = link_rdata[IDX_W-1:0];
            head_valid_in[src_ff] = link_rdata[IDX_W];
            rsp_valid_in          = 1'b1;
            rsp_page_address_in   = page_bytes[31:0];
            rsp_source_cpu_in     = 3'(src_ff);
            state_in              = ST_IDLE;
         end

         ST_FREE_CHK: begin
            head_raddr = req_cpu_ff;
            if (free_bad) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_BAD;
               state_in      = ST_IDLE;
            end else begin
               idx_in   = free_off;
               state_in = ST_FREE_WRITE;
            end
         end

         ST_FREE_WRITE: begin
            // push: old head goes into the page's link, page becomes head
            link_we                   = 1'b1;
            link_waddr                = idx_ff[IDX_W-1:0];
            link_wdata                = {head_valid_ff[req_cpu_ff], head_rdata};
            head_we                   = 1'b1;
            head_waddr                = req_cpu_ff;
            head_wdata                = idx_ff[IDX_W-1:0];
            head_valid_in[req_cpu_ff] = 1'b1;
            rsp_valid_in              = 1'b1;
            state_in                  = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- config
   always_comb begin
      csr_kernel_end_in = csr_kernel_end_ff;
      csr_phys_top_in   = csr_phys_top_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KERNEL_END: csr_kernel_end_in = csr_data;
            CSR_PHYS_TOP:   csr_phys_top_in   = csr_data;
            default:        csr_kernel_end_in = csr_kernel_end_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         head_valid_ff     <= '0;
         csr_kernel_end_ff <= KERNEL_END_RESET;
         csr_phys_top_ff   <= PHYS_TOP_RESET;
         base_page_ff      <= BASE_PAGE_RESET;
         rsp_valid_ff      <= 1'b0;
         init_cpu_ff       <= '0;
      end else begin
         state_ff          <= state_in;
         head_valid_ff     <= head_valid_in;
         csr_kernel_end_ff <= csr_kernel_end_in;
         csr_phys_top_ff   <= csr_phys_top_in;
         base_page_ff      <= base_page_in;
         rsp_valid_ff      <= rsp_valid_in;
         init_cpu_ff       <= init_cpu_in;
      end
      req_cpu_ff          <= req_cpu_in;
      req_address_ff      <= req_address_in;
      src_ff              <= src_in;
      idx_ff              <= idx_in;
      per_ff              <= per_in;
      first_ff            <= first_in;
      next_first_ff       <= next_first_in;
      prev_valid_ff       <= prev_valid_in;
      prev_idx_ff         <= prev_idx_in;
      rsp_page_address_ff <= rsp_page_address_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_source_cpu_ff   <= rsp_source_cpu_in;
   end

   // ---------------------------------------------------------------- units
   pcpa_div #(
      .WIDTH   (TW),
      .DIVISOR (CPU_COUNT)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (span_page_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   pcpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CPU_COUNT)
   ) u_head_ram (
      .clock         (clock),
      .write_enable  (head_we),
      .write_address (head_waddr),
      .write_data    (head_wdata),
      .read_address  (head_raddr),
      .read_data     (head_rdata)
   );

   pcpa_ram #(
      .WIDTH (IDX_W + 1),
      .DEPTH (MAX_PAGES)
   ) u_link_ram (
      .clock         (clock),
      .write_enable  (link_we),
      .write_address (link_waddr),
      .write_data    (link_wdata),
      .read_address  (link_raddr),
      .read_data     (link_rdata)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_page_address_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_source_cpu   = rsp_source_cpu_ff;

endmodule
